@@ design/ltr_calc_pkg.sv @@
// Package for the left-to-right expression calculator.
// Holds the character codes, operator codes and step-count constants.
// No dependencies.
package ltr_calc_pkg;

    // ASCII codes the calculator understands
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQUAL = 8'h3D;

    // Data path width
    localparam int DATA_W = 32;

    // Pending operator codes
    typedef logic [1:0] op_t;
    localparam op_t OP_ADD = 2'd0;
    localparam op_t OP_SUB = 2'd1;
    localparam op_t OP_MUL = 2'd2;
    localparam op_t OP_DIV = 2'd3;

    // One multiply or divide step per data bit
    localparam int STEPS     = DATA_W;
    localparam int CNT_W     = $clog2(STEPS);
    localparam int STEP_LAST = STEPS - 1;

endpackage

@@ design/left_to_right_expression_calculator.sv @@
// A digit is taken in the idle state; an operator folds the pending operator through the
// operator state, then for multiply the multiply steps and for divide the divide steps and
// the sign fix; '=' then loads the result, a divide by zero or an invalid character loads an
// error result, and a full result register stalls the load. A new character is taken only
// when back in idle; multiply and divide run 32 steps through the shared 33-bit adder.
// Reset (rst_n, asynchronous, active low): total and operand clear, pending add, no result.
module left_to_right_expression_calculator
    import ltr_calc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        char_code,
    output logic              out_valid,
    input  logic              out_stall,
    output logic signed [31:0] value,
    output logic              is_error
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_OPER = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIX  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0]        state_reg,   state_next;
    logic [DATA_W-1:0] total_reg,   total_next;
    logic [DATA_W-1:0] operand_reg, operand_next;
    op_t               pend_reg,    pend_next;
    op_t               nop_reg,     nop_next;
    logic              eq_reg,      eq_next;
    logic              err_reg,     err_next;
    logic              neg_reg,     neg_next;
    logic [CNT_W-1:0]  cnt_reg,     cnt_next;
    logic [DATA_W-1:0] a_reg,       a_next;
    logic [DATA_W-1:0] b_reg,       b_next;
    logic [DATA_W-1:0] q_reg,       q_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] value_reg,   value_next;
    logic              is_error_reg, is_error_next;

    // Shared adder/subtractor
    logic [DATA_W:0]   alu_a, alu_b, alu_sum;
    logic              alu_sub;

    logic              fin;
    logic [DATA_W-1:0] fin_val;
    logic [3:0]        digit;
    logic [DATA_W-1:0] digit_ext;
    logic [DATA_W-1:0] total_abs, operand_abs;
    logic              last_step;

    assign alu_sum = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);

    // Operand times ten plus the new digit
    assign digit     = 4'(char_code - CH_ZERO);
    assign digit_ext = {operand_reg[DATA_W-4:0], 3'b000}
                     + {operand_reg[DATA_W-2:0], 1'b0}
                     + {{(DATA_W-4){1'b0}}, digit};

    assign total_abs   = total_reg[DATA_W-1]   ? (-total_reg)   : total_reg;
    assign operand_abs = operand_reg[DATA_W-1] ? (-operand_reg) : operand_reg;
    assign last_step   = (cnt_reg == CNT_W'(STEP_LAST));

    // Sequencer and data path
    always_comb
    begin
        state_next     = state_reg;
        total_next     = total_reg;
        operand_next   = operand_reg;
        pend_next      = pend_reg;
        nop_next       = nop_reg;
        eq_next        = eq_reg;
        err_next       = err_reg;
        neg_next       = neg_reg;
        cnt_next       = cnt_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        q_next         = q_reg;
        value_next     = value_reg;
        is_error_next  = is_error_reg;
        alu_a          = '0;
        alu_b          = '0;
        alu_sub        = 1'b0;
        fin            = 1'b0;
        fin_val        = '0;

        // Drop the result once the transaction completes
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (char_code) inside
                        [CH_ZERO:CH_NINE]:
                        begin
                            operand_next = digit_ext;
                        end
                        CH_PLUS:
                        begin
                            nop_next   = OP_ADD;
                            eq_next    = 1'b0;
                            state_next = ST_OPER;
                        end
                        CH_MINUS:
                        begin
                            nop_next   = OP_SUB;
                            eq_next    = 1'b0;
                            state_next = ST_OPER;
                        end
                        CH_STAR:
                        begin
                            nop_next   = OP_MUL;
                            eq_next    = 1'b0;
                            state_next = ST_OPER;
                        end
                        CH_SLASH:
                        begin
                            nop_next   = OP_DIV;
                            eq_next    = 1'b0;
                            state_next = ST_OPER;
                        end
                        CH_EQUAL:
                        begin
                            nop_next   = OP_ADD;
                            eq_next    = 1'b1;
                            state_next = ST_OPER;
                        end
                        default:
                        begin
                            total_next = '0;
                            err_next   = 1'b1;
                            state_next = ST_EMIT;
                        end
                    endcase
                end
            end

            ST_OPER:
            begin
                case (pend_reg)
                    OP_ADD:
                    begin
                        alu_a   = {1'b0, total_reg};
                        alu_b   = {1'b0, operand_reg};
                        fin     = 1'b1;
                        fin_val = alu_sum[DATA_W-1:0];
                    end
                    OP_SUB:
                    begin
                        alu_a   = {1'b0, total_reg};
                        alu_b   = {1'b0, operand_reg};
                        alu_sub = 1'b1;
                        fin     = 1'b1;
                        fin_val = alu_sum[DATA_W-1:0];
                    end
                    OP_MUL:
                    begin
                        a_next     = '0;
                        b_next     = total_reg;
                        q_next     = operand_reg;
                        cnt_next   = '0;
                        state_next = ST_MUL;
                    end
                    default:
                    begin
                        if (operand_reg == '0)
                        begin
                            total_next = '0;
                            err_next   = 1'b1;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            a_next     = '0;
                            b_next     = operand_abs;
                            q_next     = total_abs;
                            neg_next   = total_reg[DATA_W-1] ^ operand_reg[DATA_W-1];
                            cnt_next   = '0;
                            state_next = ST_DIV;
                        end
                    end
                endcase
            end

            // Shift-add multiply, low word kept
            ST_MUL:
            begin
                alu_a    = {1'b0, a_reg};
                alu_b    = {1'b0, b_reg};
                if (q_reg[0])
                begin
                    a_next = alu_sum[DATA_W-1:0];
                end
                b_next   = {b_reg[DATA_W-2:0], 1'b0};
                q_next   = {1'b0, q_reg[DATA_W-1:1]};
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    fin     = 1'b1;
                    fin_val = q_reg[0] ? alu_sum[DATA_W-1:0] : a_reg;
                end
            end

            // Restoring divide on magnitudes
            ST_DIV:
            begin
                alu_a    = {a_reg, q_reg[DATA_W-1]};
                alu_b    = {1'b0, b_reg};
                alu_sub  = 1'b1;
                if (!alu_sum[DATA_W])
                begin
                    a_next = alu_sum[DATA_W-1:0];
                    q_next = {q_reg[DATA_W-2:0], 1'b1};
                end
                else
                begin
                    a_next = {a_reg[DATA_W-2:0], q_reg[DATA_W-1]};
                    q_next = {q_reg[DATA_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (last_step)
                begin
                    state_next = ST_FIX;
                end
            end

            // Apply quotient sign
            ST_FIX:
            begin
                alu_b   = {1'b0, q_reg};
                alu_sub = 1'b1;
                fin     = 1'b1;
                fin_val = neg_reg ? alu_sum[DATA_W-1:0] : q_reg;
            end

            // Load the result register once it is free, then restart
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    value_next     = total_reg;
                    is_error_next  = err_reg;
                    total_next     = '0;
                    operand_next   = '0;
                    pend_next      = OP_ADD;
                    err_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Commit an operator step
        if (fin)
        begin
            total_next   = fin_val;
            operand_next = '0;
            pend_next    = nop_reg;
            err_next     = 1'b0;
            state_next   = eq_reg ? ST_EMIT : ST_IDLE;
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= '0;
            operand_reg   <= '0;
            pend_reg      <= OP_ADD;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            operand_reg   <= operand_next;
            pend_reg      <= pend_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge clk)
    begin
        nop_reg      <= nop_next;
        eq_reg       <= eq_next;
        neg_reg      <= neg_next;
        cnt_reg      <= cnt_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        q_reg        <= q_next;
        value_reg    <= value_next;
        is_error_reg <= is_error_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign is_error  = is_error_reg;

`ifndef SYNTHESIS
    // An error transaction always carries a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_error |-> value == '0)
        else $error("error result with nonzero value");

    // The divider never runs with a zero divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> b_reg != '0)
        else $error("divide step with zero divisor");

    // A free result register is loaded and the expression restarts
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && (!out_valid || !out_stall)
        |=> out_valid && state_reg == ST_IDLE && operand_reg == '0)
        else $error("result not loaded or state not restarted");
`endif

endmodule
